// File: rtl/shabc_pkg.sv
// ============================================================================
// shabc_pkg
// Shared types, constants and sigma functions of the SHA-256/224 block
// compression engine.
// ============================================================================
package shabc_pkg;

    localparam int WORD_W       = 32;
    localparam int BLOCK_WORDS  = 16;
    localparam int ROUNDS       = 64;
    localparam int DIGEST_WORDS = 8;
    localparam int WORDS_224    = 7;
    localparam int ROUND_W      = $clog2(ROUNDS);
    localparam int WCNT_W       = $clog2(BLOCK_WORDS);
    localparam int IDX_W        = $clog2(DIGEST_WORDS);

    // hash_mode codes
    localparam logic MODE_SHA256 = 1'b0;
    localparam logic MODE_SHA224 = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [DIGEST_WORDS-1:0][WORD_W-1:0] t_vars;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    // schedule window control
    typedef struct packed {
        logic shift_in;
        logic step;
    } t_sched_ctrl;

    // round unit control
    typedef struct packed {
        logic load;
        logic step;
    } t_rnd_ctrl;

    localparam t_word ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word IV_256 [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word IV_224 [DIGEST_WORDS] = '{
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
    };

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic t_word small_sig0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sig1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word big_sig0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sig1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// File: rtl/shabc_sched.sv
// ============================================================================
// shabc_sched
// Sixteen-word message schedule window. Message words shift in during
// collection; during the rounds the window rolls one word per round and
// presents W[t] at its head.
// ============================================================================
module shabc_sched (
    input  logic                   i_clk,
    input  shabc_pkg::t_sched_ctrl i_ctrl,
    input  shabc_pkg::t_word       i_word,
    output shabc_pkg::t_word       o_w
);

    shabc_pkg::t_word r_win [shabc_pkg::BLOCK_WORDS];
    shabc_pkg::t_word n_expand;

    // next schedule word from the current window
    assign n_expand = shabc_pkg::small_sig1(r_win[14]) + r_win[9]
                    + shabc_pkg::small_sig0(r_win[1]) + r_win[0];

    // shift line: new words enter at the tail
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_in || i_ctrl.step) begin
            for (int i = 0; i < shabc_pkg::BLOCK_WORDS - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[shabc_pkg::BLOCK_WORDS - 1] <= i_ctrl.shift_in ? i_word : n_expand;
        end
    end

    assign o_w = r_win[0];

endmodule

// File: rtl/shabc_round.sv
// ============================================================================
// shabc_round
// Working variables a..h and the shared round datapath; one SHA-256 round
// per step.
// ============================================================================
module shabc_round (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  shabc_pkg::t_rnd_ctrl i_ctrl,
    input  shabc_pkg::t_vars     i_load_vars,
    input  shabc_pkg::t_word     i_w,
    input  shabc_pkg::t_word     i_k,
    output shabc_pkg::t_vars     o_vars
);

    shabc_pkg::t_vars r_vars;
    shabc_pkg::t_vars n_vars;
    shabc_pkg::t_word n_t1;
    shabc_pkg::t_word n_t2;
    shabc_pkg::t_word n_ch;
    shabc_pkg::t_word n_maj;

    // round function: index 0 is a, index 7 is h
    always_comb begin
        n_ch  = (r_vars[4] & r_vars[5]) ^ (~r_vars[4] & r_vars[6]);
        n_maj = (r_vars[0] & r_vars[1]) ^ (r_vars[0] & r_vars[2])
              ^ (r_vars[1] & r_vars[2]);
        n_t1  = r_vars[7] + shabc_pkg::big_sig1(r_vars[4]) + n_ch + i_k + i_w;
        n_t2  = shabc_pkg::big_sig0(r_vars[0]) + n_maj;

        n_vars = r_vars;
        if (i_ctrl.load) begin
            n_vars = i_load_vars;
        end else if (i_ctrl.step) begin
            n_vars[7] = r_vars[6];
            n_vars[6] = r_vars[5];
            n_vars[5] = r_vars[4];
            n_vars[4] = r_vars[3] + n_t1;
            n_vars[3] = r_vars[2];
            n_vars[2] = r_vars[1];
            n_vars[1] = r_vars[0];
            n_vars[0] = n_t1 + n_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vars <= '0;
        end else begin
            r_vars <= n_vars;
        end
    end

    assign o_vars = r_vars;

endmodule

// File: rtl/sha256_block_compression_top.sv
// ============================================================================
// sha256_block_compression_top
// SHA-256/224 block compression: collects 16 message words, runs 64 rounds
// on one shared round unit, folds into the digest and streams the digest out.
// ============================================================================
// Sequence: 16 accepted words, then a load step, 64 rounds and an add step, then
//   8 (SHA-256) or 7 (SHA-224) digest words, one per cycle without stall.
// A new block is taken only after the previous digest has left; the single
//   round unit (one round per cycle) carries the whole compression phase.
// Input stall is high from the 16th word until the last digest word leaves.
// Reset (synchronous, active low) clears all state except the schedule window.
module sha256_block_compression_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_wr_data,
    // message word channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [31:0]                i_message_word,
    input  logic                       i_new_message,
    // digest word channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [31:0]                o_digest_word,
    output logic [2:0]                 o_word_index,
    output logic                       o_last_word
);

    shabc_pkg::t_state              r_state;
    shabc_pkg::t_state              n_state;
    logic                           r_mode;
    logic                           r_reload;
    logic [shabc_pkg::WCNT_W-1:0]   r_wcnt;
    logic [shabc_pkg::ROUND_W-1:0]  r_round;
    logic [shabc_pkg::IDX_W-1:0]    r_emit_idx;
    shabc_pkg::t_vars               r_digest;

    logic                           in_acc;
    logic                           out_acc;
    logic                           emit_last;
    shabc_pkg::t_sched_ctrl         sched_ctrl;
    shabc_pkg::t_rnd_ctrl           rnd_ctrl;
    shabc_pkg::t_vars               iv_vars;
    shabc_pkg::t_vars               load_vars;
    shabc_pkg::t_vars               work_vars;
    shabc_pkg::t_word               sched_w;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // final digest word depends on the current mode
    assign emit_last = (r_mode == shabc_pkg::MODE_SHA224)
                     ? (r_emit_idx == shabc_pkg::IDX_W'(shabc_pkg::WORDS_224 - 1))
                     : (r_emit_idx == shabc_pkg::IDX_W'(shabc_pkg::DIGEST_WORDS - 1));

    // initial value selected by mode
    always_comb begin
        for (int i = 0; i < shabc_pkg::DIGEST_WORDS; i++) begin
            iv_vars[i] = (r_mode == shabc_pkg::MODE_SHA224)
                       ? shabc_pkg::IV_224[i] : shabc_pkg::IV_256[i];
        end
    end

    assign load_vars = r_reload ? iv_vars : r_digest;

    // sequencer: next state and unit controls
    always_comb begin
        n_state             = r_state;
        o_in_stall          = 1'b1;
        o_out_valid         = 1'b0;
        sched_ctrl.shift_in = 1'b0;
        sched_ctrl.step     = 1'b0;
        rnd_ctrl.load       = 1'b0;
        rnd_ctrl.step       = 1'b0;
        unique case (r_state)
            shabc_pkg::ST_IDLE: begin
                o_in_stall          = 1'b0;
                sched_ctrl.shift_in = in_acc;
                if (in_acc && r_wcnt == shabc_pkg::WCNT_W'(shabc_pkg::BLOCK_WORDS - 1)) begin
                    n_state = shabc_pkg::ST_LOAD;
                end
            end
            shabc_pkg::ST_LOAD: begin
                rnd_ctrl.load = 1'b1;
                n_state       = shabc_pkg::ST_ROUND;
            end
            shabc_pkg::ST_ROUND: begin
                rnd_ctrl.step   = 1'b1;
                sched_ctrl.step = 1'b1;
                if (r_round == shabc_pkg::ROUND_W'(shabc_pkg::ROUNDS - 1)) begin
                    n_state = shabc_pkg::ST_ADD;
                end
            end
            shabc_pkg::ST_ADD: begin
                n_state = shabc_pkg::ST_EMIT;
            end
            shabc_pkg::ST_EMIT: begin
                o_out_valid = 1'b1;
                if (out_acc && emit_last) begin
                    n_state = shabc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = shabc_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shabc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // mode register, word/round/emit counters, reload flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= shabc_pkg::MODE_SHA256;
            r_reload   <= 1'b0;
            r_wcnt     <= '0;
            r_round    <= '0;
            r_emit_idx <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (in_acc) begin
                r_wcnt <= r_wcnt + 1'b1;
                if (i_new_message) begin
                    r_reload <= 1'b1;
                end
            end
            if (r_state == shabc_pkg::ST_LOAD) begin
                r_reload <= 1'b0;
            end
            if (rnd_ctrl.step) begin
                r_round <= r_round + 1'b1;
            end
            if (out_acc) begin
                r_emit_idx <= emit_last ? '0 : r_emit_idx + 1'b1;
            end
        end
    end

    // running digest: IV or chained digest at load, feed-forward add after the rounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digest <= '0;
        end else if (r_state == shabc_pkg::ST_LOAD) begin
            r_digest <= load_vars;
        end else if (r_state == shabc_pkg::ST_ADD) begin
            for (int i = 0; i < shabc_pkg::DIGEST_WORDS; i++) begin
                r_digest[i] <= r_digest[i] + work_vars[i];
            end
        end
    end

    shabc_sched u_sched (
        .i_clk  (i_clk),
        .i_ctrl (sched_ctrl),
        .i_word (i_message_word),
        .o_w    (sched_w)
    );

    shabc_round u_round (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (rnd_ctrl),
        .i_load_vars (load_vars),
        .i_w         (sched_w),
        .i_k         (shabc_pkg::ROUND_K[r_round]),
        .o_vars      (work_vars)
    );

    // output item straight from the digest; index only moves on accept
    assign o_digest_word = r_digest[r_emit_idx];
    assign o_word_index  = r_emit_idx;
    assign o_last_word   = emit_last;

endmodule

// File: rtl/shabc_checker.sv
// ============================================================================
// shabc_checker
// Port-level checks of the compression engine's channel behavior.
// ============================================================================
module shabc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // no new message item taken while digest items are being delivered
    a_stall_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input not stalled during digest output");

    // digest run ends right after its last item is taken
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_word) |=> !o_out_valid)
        else $error("output still valid after last digest word");

    // index steps by one between items of a run
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_word) |=>
            (o_out_valid && o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest word index did not advance");

    // last word sits at position 6 or 7 only
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_word) |-> (o_word_index == 3'd6 || o_word_index == 3'd7))
        else $error("last word at wrong index");

    // first item of a run is the most significant word
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_word_index == 3'd0))
        else $error("digest run does not start at index 0");

endmodule

bind sha256_block_compression_top shabc_checker u_shabc_checker (.*);

// File: bench/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the SHA-256/224 block compression engine. Message
// words are streamed in from a queue, every accepted word is run through an
// in-bench SHA compression predictor, and each digest word the engine emits
// is compared against the oldest predicted word. Both channels idle at random.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_TARGET    = 470;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 8;

    // SHA-256 round constants
    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA256_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA224_INIT [8] = '{
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
    };

    // how the flag is placed within a generated block
    typedef enum {
        PLAN_FRESH,
        PLAN_CHAIN,
        PLAN_FRESH_LATE,
        PLAN_LATE_ONLY,
        PLAN_NOISE
    } t_block_plan;

    typedef struct {
        logic [31:0] word;
        logic        fresh;
    } t_msg_item;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_wr_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_message_word;
    logic        i_new_message;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    // stimulus and checking state
    t_msg_item    send_q[$];
    t_digest_item digest_q[$];
    t_block_plan  blk_plan;
    int           blk_late;
    int           words_queued;
    int           words_taken;
    int           digests_checked;
    int           blocks_224;
    int           blocks_256;
    int           mode_writes;
    int           fail_count;
    int           tx_gap;
    int           rx_gap;
    int           rx_hold;
    int           hold_req;
    int           hold_ack;
    logic         no_idle;

    // predictor state
    logic        model_mode;
    logic [31:0] model_digest [8];
    logic [31:0] model_window [16];
    logic [3:0]  model_fill;
    logic        model_reload;

    sha256_block_compression_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_message_word (i_message_word),
        .i_new_message  (i_new_message),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_digest_word  (o_digest_word),
        .o_word_index   (o_word_index),
        .o_last_word    (o_last_word)
    );

    // clock and known input values from time zero
    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = 1'b0;
        i_in_valid     = 1'b0;
        i_message_word = '0;
        i_new_message  = 1'b0;
        i_out_stall    = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // SHA helpers
    // ------------------------------------------------------------------------
    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        logic [63:0] twice;
        twice = {x, x} >> n;
        return twice[31:0];
    endfunction

    function automatic logic [31:0] msg_mix0(input logic [31:0] x);
        return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] msg_mix1(input logic [31:0] x);
        return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] sum_a(input logic [31:0] x);
        return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic logic [31:0] sum_e(input logic [31:0] x);
        return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

    // 64 rounds over the collected block, folded into the running digest
    task automatic fold_block();
        logic [31:0] sched [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int t = 0; t < 16; t++) sched[t] = model_window[t];
        for (int t = 16; t < 64; t++)
            sched[t] = msg_mix1(sched[t-2]) + sched[t-7] + msg_mix0(sched[t-15]) + sched[t-16];
        a = model_digest[0]; b = model_digest[1]; c = model_digest[2]; d = model_digest[3];
        e = model_digest[4]; f = model_digest[5]; g = model_digest[6]; h = model_digest[7];
        for (int t = 0; t < 64; t++) begin
            t1 = h + sum_e(e) + ((e & f) ^ (~e & g)) + ROUND_CONST[t] + sched[t];
            t2 = sum_a(a) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        model_digest[0] += a; model_digest[1] += b; model_digest[2] += c;
        model_digest[3] += d; model_digest[4] += e; model_digest[5] += f;
        model_digest[6] += g; model_digest[7] += h;
    endtask

    // one accepted message word; the 16th word of a block yields the digest
    task automatic absorb_word(input logic [31:0] word, input logic fresh);
        t_digest_item exp_word;
        int           n_out;
        if (fresh) model_reload = 1'b1;
        model_window[model_fill] = word;
        model_fill = model_fill + 4'd1;
        if (model_fill == 4'd0) begin
            if (model_reload) begin
                for (int k = 0; k < 8; k++) begin
                    if (model_mode == shabc_pkg::MODE_SHA224) model_digest[k] = SHA224_INIT[k];
                    else                                      model_digest[k] = SHA256_INIT[k];
                end
                model_reload = 1'b0;
            end
            fold_block();
            if (model_mode == shabc_pkg::MODE_SHA224) begin
                n_out = 7;
                blocks_224++;
            end else begin
                n_out = 8;
                blocks_256++;
            end
            for (int k = 0; k < n_out; k++) begin
                exp_word.word  = model_digest[k];
                exp_word.index = k[2:0];
                exp_word.last  = (k == n_out - 1);
                digest_q.push_back(exp_word);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Idle lengths: mostly none or short, now and then long
    // ------------------------------------------------------------------------
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents queued items, holds them while stalled
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_gap = 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) tx_gap = no_idle ? 0 : idle_len();
            if (tx_gap > 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (send_q.size() > 0) begin
                i_in_valid     <= 1'b1;
                i_message_word <= send_q[0].word;
                i_new_message  <= send_q[0].fresh;
                send_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Predictor: tracks config writes and accepted message words
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_mode   = shabc_pkg::MODE_SHA256;
            model_fill   = '0;
            model_reload = 1'b0;
            for (int k = 0; k < 8; k++) model_digest[k] = '0;
        end else begin
            if (i_cfg_wr_en) model_mode = i_cfg_wr_data;
            if (i_in_valid && !o_in_stall) begin
                words_taken++;
                absorb_word(i_message_word, i_new_message);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks digest words, drives random and long receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_digest_item exp_word;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_gap  = 0;
            rx_hold = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (digest_q.size() == 0) begin
                    $error("digest word %08h arrived with nothing expected", o_digest_word);
                    fail_count++;
                end else begin
                    exp_word = digest_q.pop_front();
                    digests_checked++;
                    if (o_digest_word !== exp_word.word) begin
                        $error("digest_word: expected %08h, got %08h",
                               exp_word.word, o_digest_word);
                        fail_count++;
                    end
                    if (o_word_index !== exp_word.index) begin
                        $error("word_index: expected %0d, got %0d",
                               exp_word.index, o_word_index);
                        fail_count++;
                    end
                    if (o_last_word !== exp_word.last) begin
                        $error("last_word: expected %0b, got %0b",
                               exp_word.last, o_last_word);
                        fail_count++;
                    end
                end
            end
            if (hold_ack != hold_req) begin
                hold_ack = hold_req;
                rx_hold  = RX_HOLD_CYCLES;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_out_stall <= 1'b1;
            end else begin
                if (rx_gap == 0 && !no_idle) rx_gap = idle_len();
                if (rx_gap > 0) begin
                    rx_gap--;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic put_word(input logic [31:0] word, input logic fresh);
        t_msg_item item;
        item.word  = word;
        item.fresh = fresh;
        send_q.push_back(item);
        words_queued++;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 19))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // words follow the stream's block grid, so a phase may end mid-block
    task automatic add_words(input int n);
        int   pos;
        logic fresh;
        for (int i = 0; i < n; i++) begin
            pos = words_queued % 16;
            if (pos == 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: blk_plan = PLAN_FRESH;
                    6:                blk_plan = PLAN_CHAIN;
                    7:                blk_plan = PLAN_FRESH_LATE;
                    8:                blk_plan = PLAN_LATE_ONLY;
                    default:          blk_plan = PLAN_NOISE;
                endcase
                blk_late = $urandom_range(1, 15);
            end
            case (blk_plan)
                PLAN_FRESH:      fresh = (pos == 0);
                PLAN_CHAIN:      fresh = 1'b0;
                PLAN_FRESH_LATE: fresh = (pos == 0) || (pos == blk_late);
                PLAN_LATE_ONLY:  fresh = (pos == blk_late);
                default:         fresh = ($urandom_range(0, 3) == 0);
            endcase
            put_word(pick_word(), fresh);
        end
    endtask

    // sender stays quiet until every predicted digest word has come back
    task automatic drain_all();
        do @(negedge i_clk);
        while (send_q.size() != 0 || i_in_valid || digest_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        mode_writes++;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] abc_block [16];
        int          phase;
        int          n;
        blk_plan        = PLAN_FRESH;
        blk_late        = 1;
        words_queued    = 0;
        words_taken     = 0;
        digests_checked = 0;
        blocks_224      = 0;
        blocks_256      = 0;
        mode_writes     = 0;
        fail_count      = 0;
        hold_req        = 0;
        hold_ack        = 0;
        no_idle         = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // no reload ever requested: first block chains from the zero digest
        write_mode(shabc_pkg::MODE_SHA256);
        put_word(32'h0000_0000, 1'b0); put_word(32'hffff_ffff, 1'b0);
        put_word(32'h0000_0001, 1'b0); put_word(32'h8000_0000, 1'b0);
        put_word(32'h5555_5555, 1'b0); put_word(32'haaaa_aaaa, 1'b0);
        put_word(32'h7fff_ffff, 1'b0); put_word(32'hffff_fffe, 1'b0);
        put_word(32'h0123_4567, 1'b0); put_word(32'h89ab_cdef, 1'b0);
        put_word(32'h0000_ffff, 1'b0); put_word(32'hffff_0000, 1'b0);
        put_word(32'h0f0f_0f0f, 1'b0); put_word(32'hf0f0_f0f0, 1'b0);
        put_word(32'hdead_beef, 1'b0); put_word(32'hffff_ffff, 1'b0);
        drain_all();

        // padded "abc": flag only on later words (6 and 8), mode switched mid-block
        for (int i = 0; i < 16; i++) abc_block[i] = '0;
        abc_block[0]  = 32'h6162_6380;
        abc_block[15] = 32'h0000_0018;
        for (int i = 0; i < 8; i++) put_word(abc_block[i], i == 6);
        drain_all();
        write_mode(shabc_pkg::MODE_SHA224);
        for (int i = 8; i < 16; i++) put_word(abc_block[i], 1'b1 && (i == 8));
        drain_all();

        // random phases, each starting from an idle engine
        phase = 0;
        while (words_queued < WORD_TARGET) begin
            drain_all();
            case (phase)
                0:       write_mode(shabc_pkg::MODE_SHA256);
                1:       write_mode(shabc_pkg::MODE_SHA224);
                default: write_mode(logic'($urandom_range(0, 1)));
            endcase
            n = 16 * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 15);
            if (phase == 2) begin
                // receiver holds off while the sender keeps offering blocks
                add_words(64);
                hold_req++;
            end else if (phase == 4) begin
                no_idle = 1'b1;
                add_words(n);
                drain_all();
                no_idle = 1'b0;
            end else begin
                add_words(n);
            end
            phase++;
        end
        drain_all();
        repeat (20) @(posedge i_clk);

        $display("summary: %0d message words accepted, %0d digest words checked",
                 words_taken, digests_checked);
        $display("summary: %0d SHA-256 and %0d SHA-224 blocks, %0d mode writes",
                 blocks_256, blocks_224, mode_writes);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #1000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// File: sha256_block_compression_top.f
rtl/shabc_pkg.sv
rtl/shabc_sched.sv
rtl/shabc_round.sv
rtl/sha256_block_compression_top.sv
rtl/shabc_checker.sv
bench/testbench.sv
